// ===== design/dgas_pkg.sv =====
package dgas_pkg;

  localparam int unsigned MaxVertices = 64;
  localparam int unsigned VertW = $clog2(MaxVertices);
  localparam int unsigned CountW = VertW + 1;
  localparam int unsigned RowW = MaxVertices;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 3;

  localparam logic [CountW-1:0] MaxCount = CountW'(MaxVertices);

  typedef enum logic [2:0] {
    OP_ADD_EDGE   = 3'd0,
    OP_DEL_EDGE   = 3'd1,
    OP_QUERY_EDGE = 3'd2,
    OP_ADD_VERTEX = 3'd3,
    OP_DEL_VERTEX = 3'd4
  } op_e;

  typedef struct packed {
    logic            re;
    logic [VertW-1:0] raddr;
    logic            we;
    logic [VertW-1:0] waddr;
    logic [RowW-1:0]  wdata;
  } mem_req_t;

  function automatic logic [RowW-1:0] row_bit(input logic [VertW-1:0] idx);
    row_bit = RowW'(1) << idx;
  endfunction

endpackage

// ===== design/dgas_row_mem.sv =====
module dgas_row_mem
  import dgas_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            clear_i,
  input  mem_req_t        req_i,
  output logic [RowW-1:0] rdata_o
);

  logic [RowW-1:0] mem [MaxVertices];
  logic [MaxVertices-1:0] valid_q;
  logic [RowW-1:0] rdata_q;
  logic rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  // rows never written since the last clear read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rd_valid_q <= 1'b0;
    end else if (clear_i) begin
      valid_q <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.we) begin
        valid_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rd_valid_q <= valid_q[req_i.raddr];
      end
    end
  end

  assign rdata_o = rd_valid_q ? rdata_q : '0;

endmodule

// ===== design/dgas_ctrl.sv =====
module dgas_ctrl
  import dgas_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [2:0]        op_i,
  input  logic [VertW-1:0]  vertex_a_i,
  input  logic [VertW-1:0]  vertex_b_i,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_count_i,
  input  logic [RowW-1:0]   mem_rdata_i,
  output mem_req_t          mem_req_o,
  output logic              busy_o,
  output logic              result_valid_o,
  output logic              edge_present_o,
  output logic [CountW-1:0] vertex_count_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EDGE_A,
    S_EDGE_RB,
    S_EDGE_B,
    S_LOAD_A,
    S_SCAN1,
    S_RD_R,
    S_LOAD_R,
    S_SCAN2,
    S_COPY
  } state_e;

  state_e state_q;
  op_e op_q;
  logic [VertW-1:0] a_q, b_q;
  logic [RowW-1:0] row_q;
  logic [CountW-1:0] scan_q;
  logic pend_q;
  logic [VertW-1:0] pn_q;
  logic [CountW-1:0] count_q;
  logic res_valid_q, present_q;
  logic [CountW-1:0] count_out_q;

  logic scan_done, issue;
  logic [CountW-1:0] count_inc, count_dec;
  logic self_add;

  assign scan_done = scan_q[CountW-1];
  assign issue = !scan_done && row_q[scan_q[VertW-1:0]];
  assign count_inc = (count_q < MaxCount) ? count_q + CountW'(1) : count_q;
  assign count_dec = (count_q != '0) ? count_q - CountW'(1) : count_q;
  assign self_add = (vertex_a_i == vertex_b_i);

  always_comb begin
    mem_req_o = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (op_e'(op_i))
            OP_ADD_EDGE: begin
              mem_req_o.re = !self_add;
              mem_req_o.raddr = vertex_a_i;
            end
            OP_DEL_EDGE, OP_QUERY_EDGE, OP_DEL_VERTEX: begin
              mem_req_o.re = 1'b1;
              mem_req_o.raddr = vertex_a_i;
            end
            OP_ADD_VERTEX: begin
              mem_req_o.we = 1'b1;
              mem_req_o.waddr = vertex_a_i;
              mem_req_o.wdata = '0;
            end
            default: ;
          endcase
        end
      end
      S_EDGE_A: begin
        mem_req_o.we = (op_q != OP_QUERY_EDGE);
        mem_req_o.waddr = a_q;
        mem_req_o.wdata = (op_q == OP_ADD_EDGE) ? (mem_rdata_i | row_bit(b_q))
                                                : (mem_rdata_i & ~row_bit(b_q));
      end
      S_EDGE_RB, S_RD_R: begin
        mem_req_o.re = 1'b1;
        mem_req_o.raddr = b_q;
      end
      S_EDGE_B: begin
        mem_req_o.we = 1'b1;
        mem_req_o.waddr = b_q;
        mem_req_o.wdata = (op_q == OP_ADD_EDGE) ? (mem_rdata_i | row_bit(a_q))
                                                : (mem_rdata_i & ~row_bit(a_q));
      end
      S_SCAN1, S_SCAN2: begin
        // write back row read last cycle while reading the next neighbor row
        mem_req_o.we = pend_q;
        mem_req_o.waddr = pn_q;
        mem_req_o.wdata = (state_q == S_SCAN1) ?
            (mem_rdata_i & ~row_bit(a_q)) :
            ((mem_rdata_i & ~row_bit(b_q)) | row_bit(a_q));
        mem_req_o.re = issue;
        mem_req_o.raddr = scan_q[VertW-1:0];
      end
      S_COPY: begin
        mem_req_o.we = 1'b1;
        mem_req_o.waddr = a_q;
        mem_req_o.wdata = row_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q <= OP_ADD_EDGE;
      a_q <= '0;
      b_q <= '0;
      row_q <= '0;
      scan_q <= '0;
      pend_q <= 1'b0;
      pn_q <= '0;
      count_q <= '0;
      res_valid_q <= 1'b0;
      present_q <= 1'b0;
      count_out_q <= '0;
    end else begin
      res_valid_q <= 1'b0;
      present_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (cfg_we_i) begin
            count_q <= (cfg_count_i > MaxCount) ? MaxCount : cfg_count_i;
          end
          if (start_i) begin
            op_q <= op_e'(op_i);
            a_q <= vertex_a_i;
            b_q <= vertex_b_i;
            case (op_e'(op_i))
              OP_ADD_EDGE: begin
                if (self_add) begin
                  res_valid_q <= 1'b1;
                  count_out_q <= count_q;
                end else begin
                  state_q <= S_EDGE_A;
                end
              end
              OP_DEL_EDGE, OP_QUERY_EDGE: state_q <= S_EDGE_A;
              OP_DEL_VERTEX: state_q <= S_LOAD_A;
              OP_ADD_VERTEX: begin
                count_q <= count_inc;
                res_valid_q <= 1'b1;
                count_out_q <= count_inc;
              end
              default: begin
                res_valid_q <= 1'b1;
                count_out_q <= count_q;
              end
            endcase
          end
        end
        S_EDGE_A: begin
          if (op_q == OP_QUERY_EDGE) begin
            res_valid_q <= 1'b1;
            present_q <= mem_rdata_i[b_q];
            count_out_q <= count_q;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_EDGE_RB;
          end
        end
        S_EDGE_RB: state_q <= S_EDGE_B;
        S_EDGE_B: begin
          res_valid_q <= 1'b1;
          count_out_q <= count_q;
          state_q <= S_IDLE;
        end
        S_LOAD_A: begin
          row_q <= mem_rdata_i;
          scan_q <= '0;
          pend_q <= 1'b0;
          state_q <= S_SCAN1;
        end
        S_SCAN1, S_SCAN2: begin
          pend_q <= issue;
          pn_q <= scan_q[VertW-1:0];
          if (!scan_done) begin
            scan_q <= scan_q + CountW'(1);
            // the replacement row changes under the scan when it is its own neighbor
            if (state_q == S_SCAN2 && issue && scan_q[VertW-1:0] == b_q) begin
              row_q <= (row_q & ~row_bit(b_q)) | row_bit(a_q);
            end
          end else if (state_q == S_SCAN2) begin
            state_q <= S_COPY;
          end else if (a_q == b_q) begin
            count_q <= count_dec;
            res_valid_q <= 1'b1;
            count_out_q <= count_dec;
            state_q <= S_IDLE;
          end else begin
            state_q <= S_RD_R;
          end
        end
        S_RD_R: state_q <= S_LOAD_R;
        S_LOAD_R: begin
          row_q <= mem_rdata_i;
          scan_q <= '0;
          pend_q <= 1'b0;
          state_q <= S_SCAN2;
        end
        S_COPY: begin
          count_q <= count_dec;
          res_valid_q <= 1'b1;
          count_out_q <= count_dec;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign edge_present_o = present_q;
  assign vertex_count_o = count_out_q;

endmodule

// ===== design/dynamic_graph_adjacency_store.sv =====
// Add vertex, self-loop add and unused ops answer from idle; query reads row a once;
// add/delete edge updates row a, then row b; delete vertex scans row a and, with a replacement, row b, then copies it.
// Delete vertex scans one matrix row per cycle through the 1R1W row memory, per pass.
// A new transaction is taken in the cycle the previous result strobe is shown.
// Reset (and a start count write) empties the matrix at once via per-row valid bits.
// Results cannot be stalled: each is shown for one cycle only.
module dynamic_graph_adjacency_store
  import dgas_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [2:0]          op_i,
  input  logic [VertW-1:0]    vertex_a_i,
  input  logic [VertW-1:0]    vertex_b_i,
  output logic                result_valid_o,
  output logic                edge_present_o,
  output logic [CountW-1:0]   vertex_count_out_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  logic [CountW-1:0] start_count_q;
  logic reg_sel, cfg_we;
  mem_req_t mem_req;
  logic [RowW-1:0] mem_rdata;

  assign reg_sel = (paddr[ApbAddrW-1] == 1'b0);
  assign cfg_we = psel && penable && pwrite && reg_sel;
  assign pready = 1'b1;
  assign prdata = reg_sel ? {{(ApbDataW-CountW){1'b0}}, start_count_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_count_q <= '0;
    end else if (cfg_we) begin
      start_count_q <= pwdata[CountW-1:0];
    end
  end

  dgas_row_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (cfg_we),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  dgas_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .op_i           (op_i),
    .vertex_a_i     (vertex_a_i),
    .vertex_b_i     (vertex_b_i),
    .cfg_we_i       (cfg_we),
    .cfg_count_i    (pwdata[CountW-1:0]),
    .mem_rdata_i    (mem_rdata),
    .mem_req_o      (mem_req),
    .busy_o         (busy_o),
    .result_valid_o (result_valid_o),
    .edge_present_o (edge_present_o),
    .vertex_count_o (vertex_count_out_o)
  );

endmodule

// ===== tb/sv/dgas_graph_checker.sv =====
`timescale 1ns / 1ps
module dgas_graph_checker
  import dgas_pkg::*;
#(
  parameter logic [ApbAddrW-1:0] StartCountAddr = '0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  logic [2:0]          op_i,
  input  logic [VertW-1:0]    vertex_a_i,
  input  logic [VertW-1:0]    vertex_b_i,
  input  logic                result_valid_i,
  input  logic                edge_present_i,
  input  logic [CountW-1:0]   vertex_count_i,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic [ApbAddrW-1:0] paddr_i,
  input  logic [ApbDataW-1:0] pwdata_i,
  input  logic                pready_i,
  output int unsigned         pending_o,
  output int unsigned         fail_count_o
);

  typedef struct packed {
    logic              edge_present;
    logic [CountW-1:0] vertex_count;
  } graph_result_t;

  logic [RowW-1:0]   adj_rows [MaxVertices];
  logic [CountW-1:0] live_count;
  graph_result_t     expected_results_q [$];
  int unsigned       fail_count;

  task automatic clear_matrix();
    for (int r = 0; r < MaxVertices; r++) begin
      adj_rows[r] = '0;
    end
  endtask

  // Applies one transaction to the shadow graph and returns what the block must report.
  function automatic graph_result_t predict_graph_op(input logic [2:0] op,
                                                     input logic [VertW-1:0] a,
                                                     input logic [VertW-1:0] b);
    graph_result_t res;
    res = '0;
    if (a < MaxVertices && b < MaxVertices) begin
      case (op)
        OP_ADD_EDGE: begin
          if (a != b) begin
            adj_rows[a][b] = 1'b1;
            adj_rows[b][a] = 1'b1;
          end
        end
        OP_DEL_EDGE: begin
          adj_rows[a][b] = 1'b0;
          adj_rows[b][a] = 1'b0;
        end
        OP_QUERY_EDGE: begin
          res.edge_present = adj_rows[a][b];
        end
        OP_ADD_VERTEX: begin
          adj_rows[a] = '0;
          if (live_count < MaxCount) live_count++;
        end
        OP_DEL_VERTEX: begin
          // sequential on purpose: rows may be asymmetric once a stale row is left behind
          for (int n = 0; n < MaxVertices; n++) begin
            if (adj_rows[a][n]) adj_rows[n][a] = 1'b0;
          end
          if (a != b) begin
            for (int n = 0; n < MaxVertices; n++) begin
              if (adj_rows[b][n]) begin
                adj_rows[n][b] = 1'b0;
                adj_rows[n][a] = 1'b1;
              end
            end
            adj_rows[a] = adj_rows[b];
          end
          if (live_count > 0) live_count--;
        end
        default: ;
      endcase
    end
    res.vertex_count = live_count;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    graph_result_t want;
    logic [CountW-1:0] start_count;
    if (!rst_ni) begin
      clear_matrix();
      live_count = '0;
      expected_results_q.delete();
      fail_count = 0;
      pending_o <= 0;
      fail_count_o <= 0;
    end else begin
      if (result_valid_i === 1'b1) begin
        if (expected_results_q.size() == 0) begin
          $error("unexpected result: edge_present %0d, vertex_count_out %0d",
                 edge_present_i, vertex_count_i);
          fail_count++;
        end else begin
          want = expected_results_q.pop_front();
          if (edge_present_i !== want.edge_present) begin
            $error("edge_present: expected %0d, actual %0d", want.edge_present, edge_present_i);
            fail_count++;
          end
          if (vertex_count_i !== want.vertex_count) begin
            $error("vertex_count_out: expected %0d, actual %0d",
                   want.vertex_count, vertex_count_i);
            fail_count++;
          end
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == StartCountAddr) begin
        start_count = pwdata_i[CountW-1:0];
        live_count = (start_count > MaxCount) ? MaxCount : start_count;
        clear_matrix();
      end
      if (start_i && !busy_i) begin
        expected_results_q.push_back(predict_graph_op(op_i, vertex_a_i, vertex_b_i));
      end
      pending_o <= expected_results_q.size();
      fail_count_o <= fail_count;
    end
  end

endmodule

// ===== tb/sv/tb_dynamic_graph_adjacency_store.sv =====
`timescale 1ns / 1ps
module tb_dynamic_graph_adjacency_store;
  import dgas_pkg::*;

  localparam logic [ApbAddrW-1:0] StartCountAddr = '0;
  localparam int unsigned NumPhases = 6;
  localparam int unsigned ItemsPerPhase = 188;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic [2:0]          op_i;
  logic [VertW-1:0]    vertex_a_i;
  logic [VertW-1:0]    vertex_b_i;
  logic                result_valid_o;
  logic                edge_present_o;
  logic [CountW-1:0]   vertex_count_out_o;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  int unsigned pending_results;
  int unsigned checker_fails;
  int unsigned idle_pct;
  int unsigned items_sent;

  dynamic_graph_adjacency_store i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start_i),
    .busy_o             (busy_o),
    .op_i               (op_i),
    .vertex_a_i         (vertex_a_i),
    .vertex_b_i         (vertex_b_i),
    .result_valid_o     (result_valid_o),
    .edge_present_o     (edge_present_o),
    .vertex_count_out_o (vertex_count_out_o),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  dgas_graph_checker #(
    .StartCountAddr (StartCountAddr)
  ) i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .op_i           (op_i),
    .vertex_a_i     (vertex_a_i),
    .vertex_b_i     (vertex_b_i),
    .result_valid_i (result_valid_o),
    .edge_present_i (edge_present_o),
    .vertex_count_i (vertex_count_out_o),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .pready_i       (pready),
    .pending_o      (pending_results),
    .fail_count_o   (checker_fails)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  initial begin
    #(64'd20_000_000);
    $display("tb_dynamic_graph_adjacency_store: done, errors");
    $finish;
  end

  function automatic logic [VertW-1:0] pick_vertex(input int unsigned span);
    if ($urandom_range(99) < 85) return VertW'($urandom_range(span - 1));
    return VertW'($urandom);
  endfunction

  // Holds start until the transaction is taken; start stays high for back-to-back items.
  task automatic send_item(input op_e op, input logic [VertW-1:0] a,
                           input logic [VertW-1:0] b);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i    <= 1'b1;
    op_i       <= op;
    vertex_a_i <= a;
    vertex_b_i <= b;
    do @(posedge clk_i); while (busy_o);
    items_sent++;
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0 || busy_o) @(posedge clk_i);
  endtask

  task automatic write_start_count(input int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= StartCountAddr;
    pwdata  <= ApbDataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_random(input int unsigned span);
    int unsigned pick;
    logic [VertW-1:0] a;
    logic [VertW-1:0] b;
    pick = $urandom_range(99);
    a = pick_vertex(span);
    b = pick_vertex(span);
    if (pick < 8) begin
      // vertex arrives, then its neighbours as edge adds
      send_item(OP_ADD_VERTEX, a, b);
      repeat ($urandom_range(4, 1)) send_item(OP_ADD_EDGE, a, pick_vertex(span));
    end else if (pick < 16) begin
      send_item(OP_DEL_VERTEX, a, ($urandom_range(2) == 0) ? a : b);
    end else if (pick < 45) begin
      send_item(OP_ADD_EDGE, a, b);
    end else if (pick < 55) begin
      send_item(OP_DEL_EDGE, a, b);
    end else if (pick < 95) begin
      send_item(OP_QUERY_EDGE, a, b);
    end else begin
      send_item(op_e'($urandom_range(OP_DEL_VERTEX)), VertW'($urandom), VertW'($urandom));
    end
  endtask

  initial begin
    int unsigned spans [NumPhases];
    int unsigned idles [NumPhases];
    int unsigned cfg;
    spans      = '{4, 16, 64, 8, 32, 64};
    idles      = '{0, 84, 9, 84, 0, 9};
    rst_ni     <= 1'b0;
    start_i    <= 1'b0;
    op_i       <= OP_QUERY_EDGE;
    vertex_a_i <= '0;
    vertex_b_i <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;
    idle_pct   = 0;
    items_sent = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // count floor, self-loop, symmetric edges, both kinds of vertex delete
    send_item(OP_DEL_VERTEX, 6'd0, 6'd0);
    send_item(OP_ADD_VERTEX, 6'd0, 6'd63);
    send_item(OP_ADD_VERTEX, 6'd63, 6'd0);
    send_item(OP_ADD_EDGE, 6'd0, 6'd63);
    send_item(OP_ADD_EDGE, 6'd63, 6'd0);
    send_item(OP_ADD_EDGE, 6'd5, 6'd5);
    send_item(OP_QUERY_EDGE, 6'd5, 6'd5);
    send_item(OP_QUERY_EDGE, 6'd63, 6'd0);
    send_item(OP_DEL_EDGE, 6'd0, 6'd63);
    send_item(OP_QUERY_EDGE, 6'd0, 6'd63);
    send_item(OP_ADD_EDGE, 6'd1, 6'd2);
    send_item(OP_ADD_EDGE, 6'd2, 6'd3);
    send_item(OP_ADD_EDGE, 6'd1, 6'd3);
    send_item(OP_ADD_EDGE, 6'd3, 6'd63);
    send_item(OP_DEL_VERTEX, 6'd1, 6'd3);
    send_item(OP_QUERY_EDGE, 6'd1, 6'd2);
    send_item(OP_QUERY_EDGE, 6'd3, 6'd2);
    send_item(OP_DEL_VERTEX, 6'd2, 6'd2);
    send_item(OP_QUERY_EDGE, 6'd2, 6'd1);
    send_item(OP_ADD_VERTEX, 6'd2, 6'd0);
    send_item(OP_DEL_VERTEX, 6'd63, 6'd0);
    send_item(OP_QUERY_EDGE, 6'd63, 6'd63);
    drain_results();

    // full store: add vertex must saturate
    write_start_count(MaxVertices);
    send_item(OP_ADD_VERTEX, 6'd10, 6'd10);
    send_item(OP_ADD_EDGE, 6'd10, 6'd63);
    send_item(OP_DEL_VERTEX, 6'd63, 6'd10);

    for (int p = 0; p < NumPhases; p++) begin
      drain_results();
      cfg = (p == 0) ? 0 : (p == 1) ? MaxVertices : (p == 5) ? 1 : $urandom_range(MaxVertices);
      write_start_count(cfg);
      idle_pct = idles[p];
      while (items_sent < 25 + (p + 1) * ItemsPerPhase) begin
        send_random(spans[p]);
        if ($urandom_range(199) == 0) drain_results();
      end
    end

    drain_results();
    repeat (150) @(posedge clk_i);
    if (checker_fails == 0) begin
      $display("tb_dynamic_graph_adjacency_store: done, clean");
    end else begin
      $display("tb_dynamic_graph_adjacency_store: done, errors");
    end
    $finish;
  end

endmodule
